FILE: hw/rtl/ght_pkg.sv
// Shared types and codes for the generational handle table.
`default_nettype none
package ght_pkg;

  localparam int OP_W      = 2;
  localparam int SLOT_W    = 6;
  localparam int SEED_IN_W = 16;
  localparam int PAY_IN_W  = 64;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RECYCLE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_READ  = 3'b100
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/generational_handle_table_unit.sv
// Top level of the generational handle table.
//
// For each command, start is taken while busy is low, the slot's seed and
// payload come out of the synchronous RAMs in the next cycle, and the result
// is shown with done high for the cycle after that, during which busy is
// already low again so the next command can be taken. Results cannot be
// stalled; catch them on done. After reset, busy stays high while the seed
// RAM is swept to zero. Allocate takes the highest-index free slot; the free
// search runs over the used bits, which live in flops and clear at reset.
`default_nettype none
module generational_handle_table_unit #(
  parameter int SLOTS        = 64,
  parameter int SEED_BITS    = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ght_pkg::OP_W-1:0]          op,
  input  wire logic [ght_pkg::SLOT_W-1:0]        slot_index,
  input  wire logic [ght_pkg::SEED_IN_W-1:0]     seed_in,
  input  wire logic [ght_pkg::PAY_IN_W-1:0]      payload_in,
  output logic                                   done,
  output logic [ght_pkg::STATUS_W-1:0]           status,
  output logic [ght_pkg::SLOT_W-1:0]             slot_out,
  output logic [ght_pkg::SEED_IN_W-1:0]          seed_out,
  output logic [ght_pkg::PAY_IN_W-1:0]           payload_out
);

  localparam int AW = $clog2(SLOTS);

  ght_pkg::state_t state, state_next;

  logic [SLOTS-1:0]        used;
  logic [AW-1:0]           clr_addr;

  // command held through the read cycle
  ght_pkg::op_t            op_q;
  logic [ght_pkg::SLOT_W-1:0]    idx_q;
  logic [ght_pkg::SEED_IN_W-1:0] seed_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [AW-1:0]           addr_q;
  logic                    in_range_q;
  logic                    found_q;

  logic                    free_found;
  logic [AW-1:0]           free_index;
  logic                    accept;
  logic                    in_range;
  logic [AW-1:0]           rd_addr;

  logic                    seed_we;
  logic [AW-1:0]           seed_waddr;
  logic [SEED_BITS-1:0]    seed_wdata;
  logic [SEED_BITS-1:0]    seed_rd;
  logic                    pay_we;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic [SEED_BITS-1:0]    seed_inc;
  logic                    seed_match;
  logic                    used_hit;

  ght_prio #(.SLOTS(SLOTS)) u_prio (
    .used  (used),
    .found (free_found),
    .index (free_index)
  );

  assign busy     = (state != ght_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(slot_index) < SLOTS);
  assign rd_addr  = (ght_pkg::op_t'(op) == ght_pkg::OP_ALLOC) ? free_index
                                                               : AW'(slot_index);

  assign seed_inc   = seed_rd + SEED_BITS'(1);
  assign seed_match = (32'(seed_rd) == 32'(seed_q));
  assign used_hit   = in_range_q && used[addr_q];

  always_comb begin
    seed_we    = 1'b0;
    seed_waddr = addr_q;
    seed_wdata = seed_inc;
    pay_we     = 1'b0;
    if (state == ght_pkg::S_CLEAR) begin
      seed_we    = 1'b1;
      seed_waddr = clr_addr;
      seed_wdata = '0;
    end else if (state == ght_pkg::S_READ) begin
      seed_we = (op_q == ght_pkg::OP_RECYCLE) && in_range_q;
      pay_we  = (op_q == ght_pkg::OP_ALLOC) && found_q;
    end
  end

  ght_ram #(.WIDTH(SEED_BITS), .DEPTH(SLOTS)) u_seed_ram (
    .clk   (clk),
    .we    (seed_we),
    .waddr (seed_waddr),
    .wdata (seed_wdata),
    .raddr (rd_addr),
    .rdata (seed_rd)
  );

  ght_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (addr_q),
    .wdata (pay_q),
    .raddr (rd_addr),
    .rdata (pay_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ght_pkg::S_CLEAR: begin
        if (32'(clr_addr) == SLOTS - 1) begin
          state_next = ght_pkg::S_IDLE;
        end
      end
      ght_pkg::S_IDLE: begin
        if (start) begin
          state_next = ght_pkg::S_READ;
        end
      end
      ght_pkg::S_READ: begin
        state_next = ght_pkg::S_IDLE;
      end
      default: begin
        state_next = ght_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ght_pkg::S_CLEAR;
      clr_addr <= '0;
      used     <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ght_pkg::S_READ);
      if (state == ght_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ght_pkg::S_READ) begin
        if (op_q == ght_pkg::OP_ALLOC && found_q) begin
          used[addr_q] <= 1'b1;
        end else if (op_q == ght_pkg::OP_RECYCLE && in_range_q) begin
          used[addr_q] <= 1'b0;
        end
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= ght_pkg::op_t'(op);
      idx_q      <= slot_index;
      seed_q     <= seed_in;
      pay_q      <= PAYLOAD_BITS'(payload_in);
      addr_q     <= rd_addr;
      in_range_q <= in_range;
      found_q    <= free_found;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ght_pkg::S_READ) begin
      status      <= ght_pkg::ST_OK;
      slot_out    <= idx_q;
      seed_out    <= '0;
      payload_out <= '0;
      case (op_q)
        ght_pkg::OP_ALLOC: begin
          if (!found_q) begin
            status   <= ght_pkg::ST_FULL;
            slot_out <= '0;
          end else begin
            slot_out <= ght_pkg::SLOT_W'(addr_q);
            seed_out <= ght_pkg::SEED_IN_W'(32'(seed_rd));
          end
        end
        ght_pkg::OP_RECYCLE: begin
          if (in_range_q) begin
            seed_out <= ght_pkg::SEED_IN_W'(32'(seed_inc));
          end
        end
        ght_pkg::OP_LOOKUP: begin
          if (!in_range_q) begin
            status <= ght_pkg::ST_STALE;
          end else begin
            seed_out <= ght_pkg::SEED_IN_W'(32'(seed_rd));
            if (used_hit && seed_match) begin
              payload_out <= ght_pkg::PAY_IN_W'(pay_rd);
            end else begin
              status <= ght_pkg::ST_STALE;
            end
          end
        end
        default: begin
          if (in_range_q) begin
            seed_out <= ght_pkg::SEED_IN_W'(32'(seed_rd));
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ght_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ght_prio.sv
// Priority encoder: highest-index free slot over the used bits.
`default_nettype none
module ght_prio #(
  parameter int SLOTS = 64
) (
  input  wire logic [SLOTS-1:0]         used,
  output logic                          found,
  output logic [$clog2(SLOTS)-1:0]      index
);

  localparam int AW = $clog2(SLOTS);

  always_comb begin
    found = 1'b0;
    index = '0;
    // later (higher) free slots override earlier ones
    for (int i = 0; i < SLOTS; i++) begin
      if (!used[i]) begin
        found = 1'b1;
        index = AW'(i);
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_generational_handle_table_unit.sv
// Self-checking testbench for the generational handle table unit.
`timescale 1ns / 1ps
module tb_generational_handle_table_unit;

  localparam int SLOTS          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 100;
  localparam int RANDOM_ITEMS   = 730;
  localparam logic [63:0] ONES  = '1;

  typedef struct packed {
    ght_pkg::op_t                  op;
    logic [ght_pkg::SLOT_W-1:0]    slot;
    logic [ght_pkg::SEED_IN_W-1:0] seed;
    logic [ght_pkg::PAY_IN_W-1:0]  payload;
  } command_t;

  typedef struct packed {
    ght_pkg::status_t              status;
    logic [ght_pkg::SLOT_W-1:0]    slot;
    logic [ght_pkg::SEED_IN_W-1:0] seed;
    logic [ght_pkg::PAY_IN_W-1:0]  payload;
  } reply_t;

  typedef struct packed {
    command_t cmd;
    logic     pinned;
    reply_t   reply;
  } step_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  ght_pkg::op_t                  op = ght_pkg::OP_ALLOC;
  logic [ght_pkg::SLOT_W-1:0]    slot_index = '0;
  logic [ght_pkg::SEED_IN_W-1:0] seed_in = '0;
  logic [ght_pkg::PAY_IN_W-1:0]  payload_in = '0;
  logic                          busy;
  logic                          done;
  logic [ght_pkg::STATUS_W-1:0]  status;
  logic [ght_pkg::SLOT_W-1:0]    slot_out;
  logic [ght_pkg::SEED_IN_W-1:0] seed_out;
  logic [ght_pkg::PAY_IN_W-1:0]  payload_out;

  // shadow copy of the table
  logic                          slot_live [SLOTS];
  logic [ght_pkg::SEED_IN_W-1:0] slot_gen [SLOTS];
  logic [ght_pkg::PAY_IN_W-1:0]  slot_value [SLOTS];

  reply_t    replies_due [$];
  step_row_t directed_rows [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int max_gap = 3;
  int n_items = 0;
  int n_full = 0;
  int n_hits = 0;
  int n_stale = 0;

  generational_handle_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .slot_index  (slot_index),
    .seed_in     (seed_in),
    .payload_in  (payload_in),
    .done        (done),
    .status      (status),
    .slot_out    (slot_out),
    .seed_out    (seed_out),
    .payload_out (payload_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic reply_t apply_handle_op(input command_t c);
    reply_t r;
    int     pick;
    r = '0;
    r.status = ght_pkg::ST_OK;
    r.slot = c.slot;
    pick = -1;
    case (c.op)
      ght_pkg::OP_ALLOC: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_live[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          r.status = ght_pkg::ST_FULL;
          r.slot = '0;
        end else begin
          slot_live[pick] = 1'b1;
          slot_value[pick] = c.payload;
          r.slot = 6'(pick);
          r.seed = slot_gen[pick];
        end
      end
      ght_pkg::OP_RECYCLE: begin
        slot_live[c.slot] = 1'b0;
        slot_gen[c.slot] = slot_gen[c.slot] + 16'd1;
        r.seed = slot_gen[c.slot];
      end
      ght_pkg::OP_LOOKUP: begin
        r.seed = slot_gen[c.slot];
        if (slot_live[c.slot] && slot_gen[c.slot] == c.seed) r.payload = slot_value[c.slot];
        else r.status = ght_pkg::ST_STALE;
      end
      default: r.seed = slot_gen[c.slot];
    endcase
    return r;
  endfunction

  function automatic int pick_live_slot();
    int live [$];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // mostly handles that are live or one generation old, some pure noise
  function automatic command_t draw_command(input int alloc_pct, input int recycle_pct);
    command_t c;
    int       roll;
    int       kind;
    int       s;
    c.op = ght_pkg::OP_ALLOC;
    c.slot = 6'($urandom);
    c.seed = 16'($urandom);
    c.payload = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    kind = $urandom_range(0, 19);
    s = pick_live_slot();
    if (roll < alloc_pct) begin
      c.op = ght_pkg::OP_ALLOC;
    end else if (roll < alloc_pct + recycle_pct) begin
      c.op = ght_pkg::OP_RECYCLE;
      if (s >= 0 && kind < 16) c.slot = 6'(s);
    end else if (roll < 96) begin
      c.op = ght_pkg::OP_LOOKUP;
      if (s >= 0 && kind < 11) begin
        c.slot = 6'(s);
        c.seed = slot_gen[s];
      end else if (kind < 15) begin
        c.seed = slot_gen[c.slot] - 16'd1;
      end else if (kind < 17) begin
        c.seed = slot_gen[c.slot];
      end
    end else begin
      c.op = ght_pkg::OP_NONE;
    end
    return c;
  endfunction

  task automatic add_row(input ght_pkg::op_t o, input logic [5:0] s, input logic [15:0] sd,
                         input logic [63:0] p, input logic pin, input ght_pkg::status_t st,
                         input logic [5:0] so, input logic [15:0] seo, input logic [63:0] po);
    step_row_t row;
    row.cmd = '{op: o, slot: s, seed: sd, payload: p};
    row.pinned = pin;
    row.reply = '{status: st, slot: so, seed: seo, payload: po};
    directed_rows.push_back(row);
  endtask

  // drive one command and hold it until the transfer happens
  task automatic issue(input command_t c, input logic pinned, input reply_t pinned_reply);
    int     gap;
    reply_t r;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= c.op;
    slot_index <= c.slot;
    seed_in    <= c.seed;
    payload_in <= c.payload;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_handle_op(c);
    replies_due.push_back(pinned ? pinned_reply : r);
    n_items++;
    if (r.status == ght_pkg::ST_FULL) n_full++;
    if (c.op == ght_pkg::OP_LOOKUP && r.status == ght_pkg::ST_OK) n_hits++;
    if (r.status == ght_pkg::ST_STALE) n_stale++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: result with none outstanding, expected nothing, actual %0h/%0h/%0h/%0h",
                   $time, status, slot_out, seed_out, payload_out);
      end else begin
        want = replies_due.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("slot_out", 64'(want.slot), 64'(slot_out));
        check_field("seed_out", 64'(want.seed), 64'(seed_out));
        check_field("payload_out", want.payload, payload_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    command_t c;
    int       round_left;
    int       alloc_pct;
    int       recycle_pct;
    int       issued;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
      slot_value[i] = '0;
    end

    // fresh table: unused lookup, allocs from the top, stale and double recycles
    add_row(ght_pkg::OP_LOOKUP, 6'd0, 16'h0000, ONES, 1'b1,
            ght_pkg::ST_STALE, 6'd0, 16'd0, 64'd0);
    add_row(ght_pkg::OP_ALLOC, 6'd0, 16'hffff, ONES, 1'b1,
            ght_pkg::ST_OK, 6'd63, 16'd0, 64'd0);
    add_row(ght_pkg::OP_ALLOC, 6'd63, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd0, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd63, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd63, 16'd0, ONES);
    add_row(ght_pkg::OP_LOOKUP, 6'd62, 16'h0000, ONES, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd0, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd63, 16'hffff, 64'd0, 1'b1,
            ght_pkg::ST_STALE, 6'd63, 16'd0, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd63, 16'h0001, 64'd0, 1'b1,
            ght_pkg::ST_STALE, 6'd63, 16'd0, 64'd0);
    add_row(ght_pkg::OP_RECYCLE, 6'd63, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd63, 16'd1, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd63, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_STALE, 6'd63, 16'd1, 64'd0);
    add_row(ght_pkg::OP_RECYCLE, 6'd0, 16'hffff, ONES, 1'b1,
            ght_pkg::ST_OK, 6'd0, 16'd1, 64'd0);
    add_row(ght_pkg::OP_RECYCLE, 6'd0, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd0, 16'd2, 64'd0);
    add_row(ght_pkg::OP_NONE, 6'd62, 16'hffff, ONES, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd0, 64'd0);
    add_row(ght_pkg::OP_NONE, 6'd0, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd0, 16'd2, 64'd0);
    add_row(ght_pkg::OP_ALLOC, 6'd5, 16'h1234, 64'h8000_0000_0000_0001, 1'b1,
            ght_pkg::ST_OK, 6'd63, 16'd1, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd63, 16'h0001, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd63, 16'd1, 64'h8000_0000_0000_0001);
    add_row(ght_pkg::OP_RECYCLE, 6'd62, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd1, 64'd0);
    add_row(ght_pkg::OP_RECYCLE, 6'd62, 16'h0000, 64'd0, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd2, 64'd0);
    add_row(ght_pkg::OP_ALLOC, 6'd0, 16'h0000, 64'h5555_5555_5555_5555, 1'b1,
            ght_pkg::ST_OK, 6'd62, 16'd2, 64'd0);
    add_row(ght_pkg::OP_ALLOC, 6'd0, 16'h0000, 64'haaaa_aaaa_aaaa_aaaa, 1'b1,
            ght_pkg::ST_OK, 6'd61, 16'd0, 64'd0);
    add_row(ght_pkg::OP_LOOKUP, 6'd62, 16'h0002, 64'd0, 1'b0, ght_pkg::ST_OK, '0, '0, '0);
    add_row(ght_pkg::OP_LOOKUP, 6'd61, 16'h0000, 64'd0, 1'b0, ght_pkg::ST_OK, '0, '0, '0);
    add_row(ght_pkg::OP_LOOKUP, 6'd62, 16'h0001, 64'd0, 1'b0, ght_pkg::ST_OK, '0, '0, '0);
    add_row(ght_pkg::OP_RECYCLE, 6'd61, 16'h0000, 64'd0, 1'b0, ght_pkg::ST_OK, '0, '0, '0);
    add_row(ght_pkg::OP_LOOKUP, 6'd61, 16'h0000, 64'd0, 1'b0, ght_pkg::ST_OK, '0, '0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].reply);

    // first round is allocate-heavy so the table fills up and reports full
    issued = 0;
    round_left = 100;
    alloc_pct = 92;
    recycle_pct = 3;
    while (issued < RANDOM_ITEMS) begin
      if (round_left == 0) begin
        round_left = $urandom_range(40, 120);
        max_gap = ($urandom_range(0, 3) == 0) ? 0 : 3;
        case ($urandom_range(0, 2))
          0: begin alloc_pct = 85; recycle_pct = 5; end
          1: begin alloc_pct = 10; recycle_pct = 55; end
          default: begin alloc_pct = 40; recycle_pct = 20; end
        endcase
      end
      c = draw_command(alloc_pct, recycle_pct);
      issue(c, 1'b0, '0);
      issued++;
      round_left--;
    end

    // one last allocate and a matching lookup
    max_gap = 3;
    c = draw_command(100, 0);
    issue(c, 1'b0, '0);
    c = draw_command(0, 0);
    c.op = ght_pkg::OP_LOOKUP;
    c.slot = 6'(pick_live_slot());
    c.seed = slot_gen[c.slot];
    issue(c, 1'b0, '0);

    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d commands: %0d table-full allocations, %0d lookup hits, %0d stale lookups,",
             n_items, n_full, n_hits, n_stale);
    $display("with idle gaps of 0 to 3 cycles between transfers; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
